/* hdl/bepe_pkg.sv */
// ----------------------------------------------------------------------------
// bepe_pkg
// Shared types and codes of the bootloader erase and program engine.
// ----------------------------------------------------------------------------
package bepe_pkg;

    localparam int MAX_WORDS_DEF = 63;
    localparam int IDX_W         = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_LOG2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_APP_PAGES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_PAGES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OBF_KEY      = 3'd4;

    localparam logic [1:0] KIND_ERASE  = 2'd0;
    localparam logic [1:0] KIND_PROG   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic CHAN_ERASE = 1'b0;
    localparam logic CHAN_PROG  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       end_of_packet;
        logic       include_data_area;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [15:0] halfword;
        logic        channel;
        logic        success;
        logic        final_item;
    } t_out_item;

endpackage

/* hdl/bepe_ram.sv */
// ----------------------------------------------------------------------------
// bepe_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bepe_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 63,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/bootloader_erase_program_engine_top.sv */
// ----------------------------------------------------------------------------
// bootloader_erase_program_engine_top
// Erase and program command engine: page erase sweeps and packet programming.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready  o_out_item (t_out_item)
//  cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
//  A packet byte without end of packet leaves the engine idle, ready for the
//  next byte. An erase command emits one erase request per page and then its
//  status. A final packet byte starts the checks (limit, end, compare, low
//  bound; only the first when nothing is erased or the packet is shorter than
//  six bytes) and then, if accepted, a buffer read and an emit per halfword,
//  then the status; the shared 38-bit adder and the registered buffer read set
//  this order. Reset is synchronous and active low. A stalled output holds the sequencer in place.
// ----------------------------------------------------------------------------
module bootloader_erase_program_engine_top
    import bepe_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RAM_AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int ALU_W  = 38;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ERASE   = 4'd1;
    localparam logic [3:0] S_CHK_LIM = 4'd2;
    localparam logic [3:0] S_CHK_END = 4'd3;
    localparam logic [3:0] S_CHK_CMP = 4'd4;
    localparam logic [3:0] S_CHK_LO  = 4'd5;
    localparam logic [3:0] S_RD      = 4'd6;
    localparam logic [3:0] S_EMIT    = 4'd7;
    localparam logic [3:0] S_STAT    = 4'd8;

    // Configuration
    logic [31:0] r_region_start;
    logic [4:0]  r_page_log2;
    logic [4:0]  r_app_pages;
    logic [4:0]  r_data_pages;
    logic [15:0] r_obf_key;

    // Command state
    logic [3:0]       r_state;
    logic             r_erased;
    logic [7:0]       r_plen;
    logic [7:0]       r_len;
    logic [31:0]      r_target;
    logic [7:0]       r_count;
    logic [7:0]       r_low_hold;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_pages;
    logic             r_ok;
    logic [ALU_W-1:0] r_lim;
    logic [ALU_W-1:0] r_end;

    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic             emit;
    logic             slot;
    logic             in_fire;

    // Shared adder and shifter
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_sub;
    logic [ALU_W-1:0] alu_sum;
    logic [IDX_W-1:0] shift_in;
    logic [ALU_W-1:0] shift_out;

    // Packet assembly
    logic [7:0]       off;
    logic [6:0]       word_idx;
    logic             ram_we;
    logic             ram_re;
    logic [15:0]      ram_rdata;
    logic [15:0]      hw;
    logic [7:0]       new_len;
    logic [9:0]       expect_len;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign slot       = !r_out_valid || i_out_ready;

    assign shift_out = {{(ALU_W-IDX_W){1'b0}}, shift_in} << r_page_log2;
    assign alu_sum   = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(ALU_W-1){1'b0}}, alu_sub};

    always_comb begin
        alu_a    = {{(ALU_W-32){1'b0}}, r_region_start};
        alu_b    = shift_out;
        alu_sub  = 1'b0;
        shift_in = r_idx;
        case (r_state)
            S_CHK_LIM: begin
                shift_in = {{(IDX_W-5){1'b0}}, r_app_pages};
            end
            S_CHK_END: begin
                alu_a = {{(ALU_W-32){1'b0}}, r_target};
                alu_b = {{(ALU_W-9){1'b0}}, r_count, 1'b0};
            end
            S_CHK_CMP: begin
                alu_a   = r_lim;
                alu_b   = r_end;
                alu_sub = 1'b1;
            end
            S_CHK_LO: begin
                alu_a   = {{(ALU_W-32){1'b0}}, r_target};
                alu_b   = {{(ALU_W-32){1'b0}}, r_region_start};
                alu_sub = 1'b1;
            end
            S_EMIT: begin
                alu_a = {{(ALU_W-32){1'b0}}, r_target};
                alu_b = {{(ALU_W-IDX_W-1){1'b0}}, r_idx, 1'b0};
            end
            default: begin
            end
        endcase
    end

    // A stored word that is zero or equal to the key passes unchanged.
    assign hw = ((ram_rdata != 16'd0) && (ram_rdata != r_obf_key)) ?
                (ram_rdata ^ r_obf_key) : ram_rdata;

    always_comb begin
        n_out = '0;
        emit  = 1'b0;
        case (r_state)
            S_ERASE: begin
                emit = 1'b1;
                if (r_idx == r_pages) begin
                    n_out.kind       = KIND_STATUS;
                    n_out.channel    = CHAN_ERASE;
                    n_out.success    = 1'b1;
                    n_out.final_item = 1'b1;
                end else begin
                    n_out.kind    = KIND_ERASE;
                    n_out.address = alu_sum[31:0];
                end
            end
            S_EMIT: begin
                emit           = 1'b1;
                n_out.kind     = KIND_PROG;
                n_out.address  = alu_sum[31:0];
                n_out.halfword = hw;
            end
            S_STAT: begin
                emit             = 1'b1;
                n_out.kind       = KIND_STATUS;
                n_out.channel    = CHAN_PROG;
                n_out.success    = r_ok;
                n_out.final_item = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign off        = r_plen - 8'd6;
    assign word_idx   = off[7:1];
    assign ram_we     = in_fire && !i_in_item.action && (r_plen >= 8'd6) && (r_plen != 8'd255)
                        && off[0] && ({25'd0, word_idx} < MAX_WORDS);
    assign ram_re     = (r_state == S_RD);
    assign new_len    = (r_plen == 8'd255) ? r_plen : r_plen + 8'd1;
    assign expect_len = {1'b0, r_count, 1'b0} + 10'd6;

    bepe_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WORDS),
        .ADDR_W(RAM_AW)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(word_idx[RAM_AW-1:0]),
        .i_wdata({i_in_item.data_byte, r_low_hold}),
        .i_re   (ram_re),
        .i_raddr(r_idx[RAM_AW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_start <= '0;
            r_page_log2    <= 5'd10;
            r_app_pages    <= '0;
            r_data_pages   <= '0;
            r_obf_key      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_REGION_START: r_region_start <= i_cfg_data;
                REG_PAGE_LOG2:    r_page_log2    <= i_cfg_data[4:0];
                REG_APP_PAGES:    r_app_pages    <= i_cfg_data[4:0];
                REG_DATA_PAGES:   r_data_pages   <= i_cfg_data[4:0];
                REG_OBF_KEY:      r_obf_key      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot && emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHK_LIM) begin
            r_lim <= alu_sum;
        end
        if (r_state == S_CHK_END) begin
            r_end <= alu_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_erased   <= 1'b0;
            r_plen     <= '0;
            r_len      <= '0;
            r_target   <= '0;
            r_count    <= '0;
            r_low_hold <= '0;
            r_idx      <= '0;
            r_pages    <= '0;
            r_ok       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in_item.action) begin
                            r_idx   <= '0;
                            r_pages <= {1'b0, r_app_pages} +
                                       (i_in_item.include_data_area ?
                                        {1'b0, r_data_pages} : {IDX_W{1'b0}});
                            r_state <= S_ERASE;
                        end else begin
                            if ((r_plen >= 8'd1) && (r_plen <= 8'd4)) begin
                                r_target <= {r_target[23:0], i_in_item.data_byte};
                            end else if (r_plen == 8'd5) begin
                                r_count <= i_in_item.data_byte;
                            end else if ((r_plen >= 8'd6) && (r_plen != 8'd255) && !off[0]) begin
                                r_low_hold <= i_in_item.data_byte;
                            end
                            if (i_in_item.end_of_packet) begin
                                r_plen  <= '0;
                                r_len   <= new_len;
                                r_ok    <= r_erased && (new_len >= 8'd6);
                                r_state <= S_CHK_LIM;
                            end else begin
                                r_plen <= new_len;
                            end
                        end
                    end
                end
                S_ERASE: begin
                    if (slot) begin
                        if (r_idx == r_pages) begin
                            r_erased <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_CHK_LIM: begin
                    // The narrow checks need the count byte, which may have
                    // arrived with the final byte itself.
                    if (!r_ok) begin
                        r_state <= S_STAT;
                    end else begin
                        r_ok    <= ({2'b0, r_len} == expect_len) &&
                                   ({24'd0, r_count} <= MAX_WORDS);
                        r_state <= S_CHK_END;
                    end
                end
                S_CHK_END: begin
                    r_state <= S_CHK_CMP;
                end
                S_CHK_CMP: begin
                    if (alu_sum[ALU_W-1]) begin
                        r_ok <= 1'b0;
                    end
                    r_state <= S_CHK_LO;
                end
                S_CHK_LO: begin
                    r_idx <= '0;
                    if (r_ok && !alu_sum[ALU_W-1] && (r_count != 8'd0)) begin
                        r_state <= S_RD;
                    end else begin
                        if (alu_sum[ALU_W-1]) begin
                            r_ok <= 1'b0;
                        end
                        r_state <= S_STAT;
                    end
                end
                S_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot) begin
                        r_idx <= r_idx + 1'b1;
                        if (({2'b0, r_idx} + 8'd1) == r_count) begin
                            r_state <= S_STAT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_STAT: begin
                    if (slot) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_final_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.final_item) |-> (r_out.kind == KIND_STATUS))
        else $error("final item is not a status item");

    a_erase_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.action) |=> (r_state == S_ERASE))
        else $error("erase command did not start the page sweep");

    a_erased_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_erased))
        else $error("erased flag cleared without reset");

    a_prog_needs_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (slot && emit && (n_out.kind == KIND_PROG)) |-> (r_erased && r_ok))
        else $error("halfword program issued for a rejected packet");
`endif

endmodule

/* verif/bepe_flash_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bepe_flash_checker
// Watches the channels of the erase and program engine, works out the flash
// requests and status items that each accepted command item should cause, and
// compares every output item with the oldest one still due.
// ----------------------------------------------------------------------------
module bepe_flash_checker
    import bepe_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count = 0,
    output int                    o_pending = 0
);

    logic [31:0] region_start;
    logic [4:0]  page_log2;
    logic [4:0]  app_pages;
    logic [4:0]  data_pages;
    logic [15:0] obf_key;

    logic        erased;
    logic [7:0]  byte_count;
    logic [31:0] target_addr;
    logic [7:0]  word_count;
    logic [7:0]  low_hold;
    logic [15:0] word_store [MAX_WORDS];

    t_out_item   flash_requests_due [$];
    int          fails = 0;

    task automatic queue_request(input logic [1:0] kind, input logic [31:0] addr,
                                 input logic [15:0] hw, input logic chan,
                                 input logic ok, input logic last);
        t_out_item r;
        r.kind       = kind;
        r.address    = addr;
        r.halfword   = hw;
        r.channel    = chan;
        r.success    = ok;
        r.final_item = last;
        flash_requests_due.push_back(r);
    endtask

    task automatic compute_flash_requests(input t_in_item it);
        int          npages;
        int          off;
        int          len;
        logic        ok;
        logic [63:0] pg;
        logic [63:0] limit;
        logic [63:0] span_end;
        logic [15:0] w;
        // The action flag set means an erase command; its byte fields are ignored.
        if (it.action) begin
            npages = app_pages + (it.include_data_area ? data_pages : 5'd0);
            for (int i = 0; i < npages; i++) begin
                pg = i;
                pg = region_start + (pg << page_log2);
                queue_request(KIND_ERASE, pg[31:0], 16'h0, 1'b0, 1'b0, 1'b0);
            end
            queue_request(KIND_STATUS, 32'h0, 16'h0, CHAN_ERASE, 1'b1, 1'b1);
            erased = 1'b1;
        end else begin
            if (byte_count >= 8'd1 && byte_count <= 8'd4) begin
                target_addr = {target_addr[23:0], it.data_byte};
            end else if (byte_count == 8'd5) begin
                word_count = it.data_byte;
            end else if (byte_count >= 8'd6 && byte_count < 8'd255) begin
                off = byte_count - 6;
                if (off % 2 == 0) begin
                    low_hold = it.data_byte;
                end else if (off / 2 < MAX_WORDS) begin
                    word_store[off / 2] = {it.data_byte, low_hold};
                end
            end
            if (byte_count != 8'd255) begin
                byte_count = byte_count + 8'd1;
            end
            if (it.end_of_packet) begin
                len        = byte_count;
                byte_count = 8'd0;
                pg         = app_pages;
                limit      = region_start + (pg << page_log2);
                ok         = erased && (len >= 6);
                if (ok) begin
                    span_end = target_addr;
                    span_end = span_end + 2 * word_count;
                    if (target_addr < region_start) ok = 1'b0;
                    if (span_end > limit) ok = 1'b0;
                    if (2 * word_count + 6 != len) ok = 1'b0;
                    if (word_count > MAX_WORDS) ok = 1'b0;
                end
                if (ok) begin
                    for (int i = 0; i < word_count; i++) begin
                        w = word_store[i];
                        // Blank and key-valued words pass through unchanged.
                        if (w != 16'h0 && w != obf_key) w = w ^ obf_key;
                        queue_request(KIND_PROG, target_addr + 2 * i, w, 1'b0, 1'b0, 1'b0);
                    end
                end
                queue_request(KIND_STATUS, 32'h0, 16'h0, CHAN_PROG, ok, 1'b1);
            end
        end
    endtask

    task automatic check_request(input t_out_item got);
        t_out_item want;
        if (flash_requests_due.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("unexpected result: kind %0d addr %h hw %h ch %b ok %b fin %b",
                         got.kind, got.address, got.halfword, got.channel, got.success,
                         got.final_item);
            end
        end else begin
            want = flash_requests_due.pop_front();
            if (got.kind !== want.kind || got.address !== want.address ||
                got.halfword !== want.halfword || got.channel !== want.channel ||
                got.success !== want.success || got.final_item !== want.final_item) begin
                fails++;
                if (fails <= 10) begin
                    $display("result differs: expected kind %0d addr %h hw %h ch %b ok %b fin %b",
                             want.kind, want.address, want.halfword, want.channel,
                             want.success, want.final_item);
                    $display("                actual   kind %0d addr %h hw %h ch %b ok %b fin %b",
                             got.kind, got.address, got.halfword, got.channel,
                             got.success, got.final_item);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            region_start = 32'h0;
            page_log2    = 5'd10;
            app_pages    = 5'd0;
            data_pages   = 5'd0;
            obf_key      = 16'h0;
            erased       = 1'b0;
            byte_count   = 8'd0;
            target_addr  = 32'h0;
            word_count   = 8'd0;
            low_hold     = 8'd0;
            flash_requests_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_REGION_START: region_start = i_cfg_data;
                    REG_PAGE_LOG2:    page_log2    = i_cfg_data[4:0];
                    REG_APP_PAGES:    app_pages    = i_cfg_data[4:0];
                    REG_DATA_PAGES:   data_pages   = i_cfg_data[4:0];
                    REG_OBF_KEY:      obf_key      = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // Results leaving now stem from earlier items, so compare first.
            if (i_out_valid && i_out_ready) check_request(i_out_item);
            if (i_in_valid && i_in_ready) compute_flash_requests(i_in_item);
        end
        o_fail_count <= fails;
        o_pending    <= flash_requests_due.size();
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives erase commands and program packets into the erase and program
// engine under several register settings and idling patterns; the checker
// beside the block predicts and compares every output item.
// ----------------------------------------------------------------------------
module tb;
    import bepe_pkg::*;

    // Far beyond the slowest correct run.
    localparam int LIMIT  = 4_000_000;
    localparam int SETTLE = 12;

    localparam logic ACT_PROGRAM = 1'b0;
    localparam logic ACT_ERASE   = 1'b1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          send_pct = 0;
    int          stall_pct = 0;
    int          phase_items = 0;
    logic [7:0]  pkt_bytes [$];
    logic [31:0] cur_rs;
    logic [4:0]  cur_log2;
    logic [4:0]  cur_app;
    logic [15:0] cur_key;

    bootloader_erase_program_engine_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bepe_flash_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        out_ready   <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        while (cycle_count < LIMIT) @(posedge i_clk);
        $display("bootloader_erase_program_engine_top: mismatch");
        $finish;
    end

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        if (send_pct > 0) begin
            while ($urandom_range(0, 99) < send_pct) gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        phase_items++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eop);
        t_in_item it;
        it.action            = ACT_PROGRAM;
        it.data_byte         = b;
        it.end_of_packet     = eop;
        it.include_data_area = $urandom_range(0, 1);
        send_item(it);
    endtask

    task automatic send_erase(input logic incl);
        t_in_item it;
        it.action            = ACT_ERASE;
        it.data_byte         = $urandom_range(0, 255);
        it.end_of_packet     = $urandom_range(0, 1);
        it.include_data_area = incl;
        send_item(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] rs, input logic [4:0] log2,
                              input logic [4:0] app, input logic [4:0] dpages,
                              input logic [15:0] key);
        write_reg(REG_REGION_START, rs);
        write_reg(REG_PAGE_LOG2, log2);
        write_reg(REG_APP_PAGES, app);
        write_reg(REG_DATA_PAGES, dpages);
        write_reg(REG_OBF_KEY, key);
        cfg_we   <= 1'b0;
        cur_rs   = rs;
        cur_log2 = log2;
        cur_app  = app;
        cur_key  = key;
        @(posedge i_clk);
    endtask

    // Mode byte, big-endian address, count, then nwords little-endian halfwords.
    task automatic build_packet(input logic [31:0] addr, input int count, input int nwords);
        logic [15:0] hw;
        int          r;
        pkt_bytes.delete();
        pkt_bytes.push_back($urandom_range(0, 255));
        pkt_bytes.push_back(addr[31:24]);
        pkt_bytes.push_back(addr[23:16]);
        pkt_bytes.push_back(addr[15:8]);
        pkt_bytes.push_back(addr[7:0]);
        pkt_bytes.push_back(count[7:0]);
        for (int i = 0; i < nwords; i++) begin
            r = $urandom_range(0, 9);
            if (r < 2) hw = 16'h0;
            else if (r < 4) hw = cur_key;
            else hw = $urandom_range(0, 65535);
            pkt_bytes.push_back(hw[7:0]);
            pkt_bytes.push_back(hw[15:8]);
        end
    endtask

    function automatic int pick_erase_slot();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, pkt_bytes.size() - 1);
        return -1;
    endfunction

    // An erase command is slipped in before byte erase_at when it is in range.
    task automatic send_packet(input int erase_at);
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            if (i == erase_at) send_erase($urandom_range(0, 1));
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        end
    endtask

    // A packet that fits the application area; count_req below zero picks one.
    task automatic send_good_packet(input int count_req);
        longint unsigned span;
        longint unsigned maxoff;
        longint unsigned room;
        int              cmax;
        int              count;
        logic [31:0]     addr;
        span = cur_app;
        span = span << cur_log2;
        cmax = (span / 2 > 63) ? 63 : int'(span / 2);
        if (count_req >= 0 && count_req <= cmax) count = count_req;
        else if ($urandom_range(0, 99) < 85) count = $urandom_range(0, (cmax < 6) ? cmax : 6);
        else count = $urandom_range(0, cmax);
        maxoff = span - 2 * count;
        room   = 64'hFFFF_FFFF - cur_rs;
        if (maxoff > room) maxoff = room;
        addr = cur_rs + ($urandom % (maxoff + 1));
        build_packet(addr, count, count);
        send_packet(pick_erase_slot());
    endtask

    initial begin
        int          r;
        int          count;
        logic [31:0] addr;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        set_config(32'h0000_2000, 5'd5, 5'd2, 5'd1, 16'h5AA5);
        build_packet(32'h0000_2000, 1, 1);      // nothing erased yet: rejected
        send_packet(-1);
        send_erase(1'b0);
        send_erase(1'b1);
        build_packet(32'h0000_2000, 3, 0);      // blank, key-valued and all-ones words
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hA5);
        pkt_bytes.push_back(8'h5A);
        pkt_bytes.push_back(8'hFF);
        pkt_bytes.push_back(8'hFF);
        send_packet(4);                         // erase arrives in the middle of the address
        pkt_bytes.delete();                     // too short
        pkt_bytes.push_back(8'h01);
        pkt_bytes.push_back(8'h20);
        send_packet(-1);

        // Random part, one register setting and idling pattern per phase.
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: set_config(32'h0, 5'd0, 5'd31, 5'd0, 16'h0);
                1: set_config(32'hFFFF_FFFF, 5'd16, 5'd31, 5'd31, 16'hFFFF);
                2: set_config(32'h100, 5'd8, 5'd0, 5'd0, $urandom_range(0, 65535));
                default: set_config($urandom, $urandom_range(0, 16), $urandom_range(0, 31),
                                    $urandom_range(0, 31), $urandom_range(0, 65535));
            endcase
            case (phase % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 48; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 48; end
                default: begin send_pct = 7; stall_pct = 7; end
            endcase
            phase_items = 0;
            if (phase == 1) begin
                // Largest runs of results, with addresses wrapping past the top.
                send_erase(1'b1);
                send_good_packet(63);
            end
            if (phase == 3) begin
                build_packet(cur_rs, 64, 64);   // count above the buffer, length exact
                send_packet(-1);
                build_packet(cur_rs, 20, 127);  // length saturates
                send_packet(-1);
                phase_items = 0;
            end
            while (phase_items < 40) begin
                r = $urandom_range(0, 99);
                if (r < 68) begin
                    send_good_packet(-1);
                end else if (r < 78) begin
                    send_erase($urandom_range(0, 1));
                end else if (r < 85) begin
                    if (cur_rs != 0 && $urandom_range(0, 1) == 1) addr = $urandom % cur_rs;
                    else addr = $urandom;
                    count = $urandom_range(0, 8);
                    build_packet(addr, count, count);
                    send_packet(pick_erase_slot());
                end else if (r < 92) begin
                    count = $urandom_range(1, 8);
                    build_packet(cur_rs, count, count + ($urandom_range(0, 1) ? 1 : -1));
                    if ($urandom_range(0, 1) == 1) void'(pkt_bytes.pop_back());
                    send_packet(pick_erase_slot());
                end else begin
                    pkt_bytes.delete();
                    count = $urandom_range(1, 12);
                    for (int i = 0; i < count; i++) pkt_bytes.push_back($urandom_range(0, 255));
                    send_packet(pick_erase_slot());
                end
                if ($urandom_range(0, 99) < 6) drain();
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("bootloader_erase_program_engine_top: match");
        end else begin
            $display("bootloader_erase_program_engine_top: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/bepe_pkg.sv
hdl/bepe_ram.sv
hdl/bootloader_erase_program_engine_top.sv
verif/bepe_flash_checker.sv
verif/tb.sv
